@@ rtl/core/iole_pkg.sv @@
// ----------------------------------------------------------------------------
// iole_pkg
// Shared types and constants for the indexed ordered list engine: item
// layouts, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package iole_pkg;

    // default sizing
    localparam int CAPACITY_DEFAULT    = 64;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // fixed field widths of the items
    localparam int FUNC_WIDTH      = 2;
    localparam int POSITION_WIDTH  = 7;
    localparam int ITEM_VALUE_WIDTH = 32;
    localparam int STATUS_WIDTH    = 3;
    localparam int HIT_WIDTH       = 6;
    localparam int LENGTH_WIDTH    = 7;

    // widest stored value supported
    localparam int VALUE_EXT_WIDTH = 64;

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_DONE      = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_RANGE     = 3'd2,
        STATUS_EMPTY     = 3'd3,
        STATUS_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_func                               func;
        logic [POSITION_WIDTH-1:0]           position_in;
        logic signed [ITEM_VALUE_WIDTH-1:0]  item_value;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic [HIT_WIDTH-1:0]      hit_position;
        logic [LENGTH_WIDTH-1:0]   length_now;
    } t_out_item;

    // handshake between the top level and the engine
    typedef struct packed {
        logic start;
        logic take;
    } t_eng_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_SHIFT_DN,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

@@ rtl/core/indexed_ordered_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine_core
// Ordered list of signed values with insert, delete, search and clear.
// ----------------------------------------------------------------------------
// One item is worked at a time. An item passes through a decode step, a walk
// step for each entry it walks and, for an insert, a place step that writes
// the new value on its own, before its result is ready. An insert walks the
// entries behind its point, a delete the entries behind the removed one, a
// search the entries up to and including the first match (or the whole
// length), and clear or a refused request walks none. The engine takes the
// next item in the cycle after it hands a result over. The walk pace is set
// by the entry memory, whose read port and write port move or compare one
// entry per cycle. The result sits in an output register, so the next item
// is taken while it waits.
module indexed_ordered_list_engine_core #(
    parameter int CAPACITY    = iole_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_WIDTH = iole_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iole_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iole_pkg::t_out_item o_out_item
);

    iole_pkg::t_eng_ctrl   eng_ctrl;
    iole_pkg::t_eng_status eng_status;
    iole_pkg::t_out_item   eng_result;

    logic                r_out_valid;
    iole_pkg::t_out_item r_out_item;

    // input side: the engine takes an item when idle
    assign o_in_ready     = eng_status.idle;
    assign eng_ctrl.start = i_in_valid && eng_status.idle;

    // output side: move a finished result when the register frees up
    assign eng_ctrl.take = eng_status.done && (!r_out_valid || i_out_ready);

    iole_engine #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (eng_ctrl),
        .i_req    (i_in_item),
        .o_status (eng_status),
        .o_result (eng_result)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ctrl.take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output item
    always_ff @(posedge i_clk) begin
        if (eng_ctrl.take) begin
            r_out_item <= eng_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/core/iole_engine.sv @@
// ----------------------------------------------------------------------------
// iole_engine
// List store and sequencer: one synchronous memory holds the entries, the
// sequencer moves or compares one entry per cycle through its two ports.
// ----------------------------------------------------------------------------
module iole_engine #(
    parameter int CAPACITY    = iole_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_WIDTH = iole_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  iole_pkg::t_eng_ctrl    i_ctrl,
    input  iole_pkg::t_in_item     i_req,
    output iole_pkg::t_eng_status  o_status,
    output iole_pkg::t_out_item    o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > iole_pkg::POSITION_WIDTH) ? CW : iole_pkg::POSITION_WIDTH;

    // entry memory, one read and one write port, registered read data
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_rdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;

    iole_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ptr, n_ptr;
    iole_pkg::t_status r_status, n_status;
    logic [iole_pkg::HIT_WIDTH-1:0] r_hit, n_hit;

    // latched request
    iole_pkg::t_func                     r_func;
    logic [iole_pkg::POSITION_WIDTH-1:0] r_pos;
    logic [VALUE_WIDTH-1:0]              r_key;

    logic [iole_pkg::VALUE_EXT_WIDTH-1:0] val_ext;
    logic [PW-1:0] pos_ext, cnt_ext, ptr_ext, cap_ext;
    logic [CW-1:0] cnt_m1, ptr_p1, ptr_m1;

    // stored value is the low bits of the field
    assign val_ext = {{(iole_pkg::VALUE_EXT_WIDTH - iole_pkg::ITEM_VALUE_WIDTH){1'b0}},
                      i_req.item_value};

    assign pos_ext = PW'(r_pos);
    assign cnt_ext = PW'(r_count);
    assign ptr_ext = PW'(r_ptr);
    assign cap_ext = PW'(CAPACITY);
    assign cnt_m1  = r_count - CW'(1);
    assign ptr_p1  = r_ptr + CW'(1);
    assign ptr_m1  = r_ptr - CW'(1);

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iole_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_hit    <= n_hit;
        if (i_ctrl.start) begin
            r_func <= i_req.func;
            r_pos  <= i_req.position_in;
            r_key  <= val_ext[VALUE_WIDTH-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_status  = r_status;
        n_hit     = r_hit;
        mem_re    = 1'b0;
        mem_raddr = r_ptr[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_ptr[AW-1:0];
        mem_wdata = r_rdata;

        unique case (r_state)
            iole_pkg::ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = iole_pkg::ST_DECODE;
                end
            end

            // check the request, start the walk
            iole_pkg::ST_DECODE: begin
                n_status = iole_pkg::STATUS_DONE;
                n_hit    = '0;
                n_state  = iole_pkg::ST_DONE;
                case (r_func)
                    iole_pkg::FUNC_INSERT: begin
                        if (cnt_ext >= cap_ext) begin
                            n_status = iole_pkg::STATUS_FULL;
                        end else if (pos_ext > cnt_ext) begin
                            n_status = iole_pkg::STATUS_RANGE;
                        end else if (pos_ext == cnt_ext) begin
                            n_state = iole_pkg::ST_PLACE;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = cnt_m1[AW-1:0];
                            n_ptr     = cnt_m1;
                            n_state   = iole_pkg::ST_SHIFT_UP;
                        end
                    end
                    iole_pkg::FUNC_DELETE: begin
                        if (r_count == '0) begin
                            n_status = iole_pkg::STATUS_EMPTY;
                        end else if (pos_ext >= cnt_ext) begin
                            n_status = iole_pkg::STATUS_RANGE;
                        end else if (pos_ext == PW'(cnt_m1)) begin
                            // last entry, nothing moves
                            n_count = cnt_m1;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(r_pos + 7'd1);
                            n_ptr     = CW'(pos_ext + PW'(1));
                            n_state   = iole_pkg::ST_SHIFT_DN;
                        end
                    end
                    iole_pkg::FUNC_SEARCH: begin
                        if (r_count == '0) begin
                            n_status = iole_pkg::STATUS_NOT_FOUND;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_ptr     = '0;
                            n_state   = iole_pkg::ST_SCAN;
                        end
                    end
                    iole_pkg::FUNC_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_state = iole_pkg::ST_DONE;
                    end
                endcase
            end

            // move entry ptr up one place, walking toward the insert point
            iole_pkg::ST_SHIFT_UP: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_p1[AW-1:0];
                mem_wdata = r_rdata;
                if (ptr_ext == pos_ext) begin
                    n_state = iole_pkg::ST_PLACE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_m1[AW-1:0];
                    n_ptr     = ptr_m1;
                end
            end

            // write the new value at the insert point
            iole_pkg::ST_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = pos_ext[AW-1:0];
                mem_wdata = r_key;
                n_count   = r_count + CW'(1);
                n_state   = iole_pkg::ST_DONE;
            end

            // move entry ptr down one place, walking toward the end
            iole_pkg::ST_SHIFT_DN: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_m1[AW-1:0];
                mem_wdata = r_rdata;
                if (r_ptr == cnt_m1) begin
                    n_count = cnt_m1;
                    n_state = iole_pkg::ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_p1[AW-1:0];
                    n_ptr     = ptr_p1;
                end
            end

            // compare one entry per cycle, stop at the first match
            iole_pkg::ST_SCAN: begin
                if (r_rdata == r_key) begin
                    n_hit   = ptr_ext[iole_pkg::HIT_WIDTH-1:0];
                    n_state = iole_pkg::ST_DONE;
                end else if (r_ptr == cnt_m1) begin
                    n_status = iole_pkg::STATUS_NOT_FOUND;
                    n_state  = iole_pkg::ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_p1[AW-1:0];
                    n_ptr     = ptr_p1;
                end
            end

            iole_pkg::ST_DONE: begin
                if (i_ctrl.take) begin
                    n_state = iole_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = iole_pkg::ST_IDLE;
            end
        endcase
    end

    // status and result
    assign o_status.idle = (r_state == iole_pkg::ST_IDLE);
    assign o_status.done = (r_state == iole_pkg::ST_DONE);

    assign o_result.status       = r_status;
    assign o_result.hit_position = r_hit;
    assign o_result.length_now   = cnt_ext[iole_pkg::LENGTH_WIDTH-1:0];

`ifndef SYNTHESIS
    // walks never read and write one entry in the same cycle
    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
        else $error("read and write hit the same entry");

    // a new value only goes in when there is room
    a_place_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iole_pkg::ST_PLACE) |=> (r_count == $past(r_count) + CW'(1)) &&
        (r_count <= CW'(CAPACITY)))
        else $error("insert overflowed the list");

    // search never looks past the held entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iole_pkg::ST_SCAN) |-> (r_ptr < r_count))
        else $error("search beyond length");

    // a request only starts an idle engine
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> (r_state == iole_pkg::ST_IDLE))
        else $error("start while busy");
`endif

endmodule

@@ tb/sv/list_engine_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_engine_checker
// Watches both channels of the ordered list engine. Every item taken on the
// input side is run through a local copy of the list to get the result it
// should produce; every result taken on the output side is compared field by
// field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module list_engine_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  iole_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  iole_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_list_len,
    output int                  o_checked,
    output int                  o_hits,
    output int                  o_full_refusals,
    output int                  o_other_refusals
);

    localparam int LIST_CAP = iole_pkg::CAPACITY_DEFAULT;
    localparam int VAL_W    = iole_pkg::ITEM_VALUE_WIDTH;
    localparam int HIT_W    = iole_pkg::HIT_WIDTH;
    localparam int LEN_W    = iole_pkg::LENGTH_WIDTH;

    // local copy of the list
    logic [VAL_W-1:0] list_vals [LIST_CAP];
    int               list_count;

    // results still owed by the engine, oldest first
    iole_pkg::t_out_item pending_results [$];

    int errors;
    int checked;
    int hits;
    int full_refusals;
    int other_refusals;

    // apply one operation to the local list and return what it reports
    function automatic iole_pkg::t_out_item apply_list_op(iole_pkg::t_in_item op);
        iole_pkg::t_out_item res;
        int                  pos;
        logic [VAL_W-1:0]    val;
        logic                found;
        res    = '0;
        res.status = iole_pkg::STATUS_DONE;
        pos    = int'(op.position_in);
        val    = op.item_value;
        found  = 1'b0;
        case (op.func)
            iole_pkg::FUNC_INSERT: begin
                if (list_count >= LIST_CAP) begin
                    res.status = iole_pkg::STATUS_FULL;
                end else if (pos > list_count) begin
                    res.status = iole_pkg::STATUS_RANGE;
                end else begin
                    for (int k = list_count; k > pos; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[pos] = val;
                    list_count++;
                end
            end
            iole_pkg::FUNC_DELETE: begin
                if (list_count == 0) begin
                    res.status = iole_pkg::STATUS_EMPTY;
                end else if (pos >= list_count) begin
                    res.status = iole_pkg::STATUS_RANGE;
                end else begin
                    for (int k = pos; k + 1 < list_count; k++)
                        list_vals[k] = list_vals[k+1];
                    list_count--;
                end
            end
            iole_pkg::FUNC_SEARCH: begin
                // first match wins, an empty list never matches
                res.status = iole_pkg::STATUS_NOT_FOUND;
                for (int k = 0; k < list_count; k++) begin
                    if (!found && list_vals[k] == val) begin
                        found            = 1'b1;
                        res.status       = iole_pkg::STATUS_DONE;
                        res.hit_position = HIT_W'(k);
                    end
                end
            end
            default: begin
                list_count = 0;
            end
        endcase
        res.length_now = LEN_W'(list_count);
        return res;
    endfunction

    // watch the channels, compare results, predict new ones
    always @(posedge i_clk) begin
        iole_pkg::t_out_item want;
        if (!i_rst_n) begin
            list_count = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    if (errors < 10)
                        $display({"[%0t] result with nothing outstanding: ",
                                  "status %0d hit %0d length %0d"},
                                 $realtime, i_out_item.status,
                                 i_out_item.hit_position, i_out_item.length_now);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (i_out_item.status !== want.status
                            || i_out_item.hit_position !== want.hit_position
                            || i_out_item.length_now !== want.length_now) begin
                        if (errors < 10)
                            $display({"[%0t] mismatch on result %0d: expected status %0d ",
                                      "hit %0d length %0d, got status %0d hit %0d ",
                                      "length %0d"},
                                     $realtime, checked, want.status, want.hit_position,
                                     want.length_now, i_out_item.status,
                                     i_out_item.hit_position, i_out_item.length_now);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = apply_list_op(i_in_item);
                pending_results.push_back(want);
                // tally what the run reached
                if (i_in_item.func == iole_pkg::FUNC_SEARCH
                        && want.status == iole_pkg::STATUS_DONE)
                    hits++;
                if (want.status == iole_pkg::STATUS_FULL)
                    full_refusals++;
                else if (want.status == iole_pkg::STATUS_RANGE
                        || want.status == iole_pkg::STATUS_EMPTY)
                    other_refusals++;
            end
        end
        o_fail_count     <= errors;
        o_pending        <= pending_results.size();
        o_list_len       <= list_count;
        o_checked        <= checked;
        o_hits           <= hits;
        o_full_refusals  <= full_refusals;
        o_other_refusals <= other_refusals;
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ordered list engine core. A short directed
// run covers the refusals and the extremes, then phases of random traffic
// grow, shrink, probe and scramble the list while both channels idle at
// random. Checking is done by the checker placed beside the engine.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIST_CAP      = iole_pkg::CAPACITY_DEFAULT;
    localparam int VAL_W         = iole_pkg::ITEM_VALUE_WIDTH;
    localparam int POS_W         = iole_pkg::POSITION_WIDTH;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int DRAIN_CYCLES  = LIST_CAP + 16;

    // traffic phases
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_PROBE  = 2;
    localparam int PH_NOISE  = 3;

    logic                logic_unused_guard;
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    iole_pkg::t_in_item  in_item   = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    iole_pkg::t_out_item out_item;

    int fail_count;
    int pending;
    int list_len;
    int checked;
    int hits;
    int full_refusals;
    int other_refusals;

    int       issued   = 0;
    int       clears   = 0;
    int       next_gap = 1;
    logic     tx_quiet = 1'b0;
    logic     rx_quiet = 1'b0;
    logic [3:0] out_wait = '0;
    logic [VAL_W-1:0] value_pool [16];

    indexed_ordered_list_engine_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    list_engine_checker u_list_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_list_len      (list_len),
        .o_checked       (checked),
        .o_hits          (hits),
        .o_full_refusals (full_refusals),
        .o_other_refusals(other_refusals)
    );

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: at random, stall after a taken item unless the side is quiet
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_wait  <= '0;
        end else if (out_ready && out_valid) begin
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            if (!rx_quiet && $urandom_range(0, 1) == 1) begin
                out_ready <= 1'b0;
                out_wait  <= 4'($urandom_range(1, 15));
            end
        end else if (!out_ready) begin
            if (out_wait <= 4'd1)
                out_ready <= 1'b1;
            else
                out_wait <= out_wait - 4'd1;
        end
    end

    // offer one operation and hold it until taken
    task automatic send_op(input iole_pkg::t_func f, input int pos,
                           input logic [VAL_W-1:0] v);
        iole_pkg::t_in_item op;
        op.func        = f;
        op.position_in = POS_W'(pos);
        op.item_value  = v;
        repeat (next_gap) @(posedge clk);
        in_item  <= op;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        issued++;
        if (f == iole_pkg::FUNC_CLEAR)
            clears++;
        next_gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (next_gap > 0)
            in_valid <= 1'b0;
    endtask

    // drop valid after the last taken item
    task automatic stop_sending();
        if (next_gap == 0)
            in_valid <= 1'b0;
        next_gap = 1;
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_drained();
        stop_sending();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 55)
            return value_pool[$urandom_range(0, 15)];
        return $urandom();
    endfunction

    // one random operation, weighted by the phase
    task automatic random_op(input int phase);
        int              len;
        int              roll;
        int              ins_pct;
        int              del_pct;
        int              clr_pct;
        int              pos;
        iole_pkg::t_func f;
        len  = list_len;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_GROW:   begin ins_pct = 75; del_pct = 10; clr_pct = 0; end
            PH_SHRINK: begin ins_pct = 10; del_pct = 75; clr_pct = 0; end
            PH_PROBE:  begin ins_pct = 20; del_pct = 20; clr_pct = 0; end
            default:   begin ins_pct = 35; del_pct = 35; clr_pct = 3; end
        endcase
        if (roll < ins_pct)
            f = iole_pkg::FUNC_INSERT;
        else if (roll < ins_pct + del_pct)
            f = iole_pkg::FUNC_DELETE;
        else if (roll < ins_pct + del_pct + clr_pct)
            f = iole_pkg::FUNC_CLEAR;
        else
            f = iole_pkg::FUNC_SEARCH;
        // mostly legal positions, some anywhere from zero up to the capacity
        if (phase == PH_NOISE || $urandom_range(0, 9) == 0)
            pos = $urandom_range(0, LIST_CAP);
        else if (f == iole_pkg::FUNC_INSERT)
            pos = $urandom_range(0, (len > LIST_CAP) ? LIST_CAP : len);
        else if (len > 0)
            pos = $urandom_range(0, len - 1);
        else
            pos = 0;
        send_op(f, pos, pick_value());
    endtask

    // stimulus
    initial begin
        int phase;
        int phase_len;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (int k = 5; k < 16; k++)
            value_pool[k] = $urandom();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: refusals on an empty list
        send_op(iole_pkg::FUNC_SEARCH, 0, 32'h0000_0000);
        send_op(iole_pkg::FUNC_DELETE, 0, 32'h0000_0000);
        send_op(iole_pkg::FUNC_INSERT, 1, 32'h1234_5678);
        // inserts at front, end and middle with extreme values
        send_op(iole_pkg::FUNC_INSERT, 0, 32'h7fff_ffff);
        send_op(iole_pkg::FUNC_INSERT, 1, 32'h8000_0000);
        send_op(iole_pkg::FUNC_INSERT, 0, 32'hffff_ffff);
        send_op(iole_pkg::FUNC_INSERT, 1, 32'h0000_0000);
        send_op(iole_pkg::FUNC_INSERT, 64, 32'h0000_0001);
        send_op(iole_pkg::FUNC_INSERT, 4, 32'h7fff_ffff);
        // searches: duplicate reports its first copy, then a miss
        send_op(iole_pkg::FUNC_SEARCH, 0, 32'h7fff_ffff);
        send_op(iole_pkg::FUNC_SEARCH, 0, 32'h8000_0000);
        send_op(iole_pkg::FUNC_SEARCH, 0, 32'h0001_2345);
        // deletes past the end, then front, last and middle
        send_op(iole_pkg::FUNC_DELETE, 5, 32'h0000_0000);
        send_op(iole_pkg::FUNC_DELETE, 64, 32'h0000_0000);
        send_op(iole_pkg::FUNC_DELETE, 0, 32'h0000_0000);
        send_op(iole_pkg::FUNC_DELETE, 3, 32'h0000_0000);
        send_op(iole_pkg::FUNC_DELETE, 1, 32'h0000_0000);
        send_op(iole_pkg::FUNC_SEARCH, 127, 32'hffff_ffff);
        // clear a list, clear an empty one
        send_op(iole_pkg::FUNC_CLEAR, 0, 32'h0000_0000);
        send_op(iole_pkg::FUNC_CLEAR, 127, 32'hffff_ffff);
        send_op(iole_pkg::FUNC_SEARCH, 0, 32'h0000_0000);
        send_op(iole_pkg::FUNC_INSERT, 0, 32'h5555_5555);
        send_op(iole_pkg::FUNC_INSERT, 0, 32'haaaa_aaaa);
        send_op(iole_pkg::FUNC_SEARCH, 0, 32'haaaa_aaaa);
        wait_drained();

        // fill to capacity, then push past it
        tx_quiet = 1'b0;
        while (list_len < LIST_CAP)
            send_op(iole_pkg::FUNC_INSERT, $urandom_range(0, list_len), pick_value());
        repeat (3)
            send_op(iole_pkg::FUNC_INSERT, $urandom_range(0, LIST_CAP), pick_value());

        // random phases
        while (issued < 24 + RANDOM_ITEMS) begin
            phase     = $urandom_range(PH_GROW, PH_NOISE);
            phase_len = $urandom_range(20, 80);
            tx_quiet  = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            repeat (phase_len)
                random_op(phase);
        end

        stop_sending();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d operations (%0d clears) and %0d checked results:",
                 issued, clears, checked);
        $display("  %0d search hits, %0d refused as full, %0d refused for position or empty",
                 hits, full_refusals, other_refusals);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
